### rtl/core/sfd_pkg.sv
package sfd_pkg;

	localparam int unsigned ADDR_W = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFC;
	localparam logic [7:0] END_BYTE  = 8'hDF;
	localparam logic [7:0] TYPE_MIN  = 8'd1;
	localparam logic [7:0] TYPE_MAX  = 8'd5;

	localparam logic [1:0] REG_GYRO   = 2'd0;
	localparam logic [1:0] REG_ACCEL  = 2'd1;
	localparam logic [1:0] REG_ORIENT = 2'd2;

	localparam logic [2:0] GYRO_RST   = 3'd3;
	localparam logic [2:0] ACCEL_RST  = 3'd4;
	localparam logic [2:0] ORIENT_RST = 3'd5;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_DATA  = 3'd2,
		PH_CHECK = 3'd3,
		PH_END   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [2:0]  frame_type;
		logic [15:0] word_zero;
		logic [15:0] word_one;
		logic [15:0] word_two;
		logic [15:0] word_three;
	} frame_t;

	typedef struct packed {
		logic [2:0] gyro;
		logic [2:0] accel;
		logic [2:0] orient;
	} type_codes_t;

endpackage

### rtl/core/sfd_if.sv
interface sfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_type;
	logic [15:0] word_zero;
	logic [15:0] word_one;
	logic [15:0] word_two;
	logic [15:0] word_three;
	logic        imu_set_complete;

	modport source (
		output valid, output frame_type, output word_zero, output word_one,
		output word_two, output word_three, output imu_set_complete, input ready
	);
	modport sink (
		input valid, input frame_type, input word_zero, input word_one,
		input word_two, input word_three, input imu_set_complete, output ready
	);
endinterface

### rtl/core/sfd_cfg.sv
module sfd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output sfd_pkg::type_codes_t       codes
);

	sfd_pkg::type_codes_t codes_q;
	logic [1:0]           reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;
	assign codes   = codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.gyro   <= sfd_pkg::GYRO_RST;
			codes_q.accel  <= sfd_pkg::ACCEL_RST;
			codes_q.orient <= sfd_pkg::ORIENT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				sfd_pkg::REG_GYRO:   codes_q.gyro   <= pwdata[2:0];
				sfd_pkg::REG_ACCEL:  codes_q.accel  <= pwdata[2:0];
				sfd_pkg::REG_ORIENT: codes_q.orient <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sfd_pkg::REG_GYRO:   prdata = {29'd0, codes_q.gyro};
			sfd_pkg::REG_ACCEL:  prdata = {29'd0, codes_q.accel};
			sfd_pkg::REG_ORIENT: prdata = {29'd0, codes_q.orient};
			default:             prdata = 32'd0;
		endcase
	end

endmodule

### rtl/core/sfd_parser.sv
module sfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	sfd_byte_if.sink          byte_ch,
	input  logic              q_full,
	output logic              push,
	output sfd_pkg::frame_t   frame
);

	sfd_pkg::phase_t phase_q;
	sfd_pkg::phase_t phase_d;
	logic [2:0]      count_q;
	logic [7:0]      check_q;
	logic [2:0]      type_q;
	logic [7:0]      store_q [8];

	logic       take;
	logic [7:0] b;
	logic       type_ok;
	logic       load_sync;
	logic       load_type;
	logic       load_data;

	assign b       = byte_ch.rx_byte;
	assign take    = byte_ch.valid & byte_ch.ready;
	assign type_ok = b inside {[sfd_pkg::TYPE_MIN:sfd_pkg::TYPE_MAX]};

	assign byte_ch.ready = (phase_q != sfd_pkg::PH_END) | ~q_full;

	always_comb begin
		case (phase_q)
			sfd_pkg::PH_TYPE:  phase_d = type_ok ? sfd_pkg::PH_DATA : sfd_pkg::PH_HUNT;
			sfd_pkg::PH_DATA:  phase_d = (count_q == 3'd7) ? sfd_pkg::PH_CHECK
			                                              : sfd_pkg::PH_DATA;
			sfd_pkg::PH_CHECK: phase_d = (b == check_q) ? sfd_pkg::PH_END : sfd_pkg::PH_HUNT;
			sfd_pkg::PH_END:   phase_d = sfd_pkg::PH_HUNT;
			default:           phase_d = (b == sfd_pkg::SYNC_BYTE) ? sfd_pkg::PH_TYPE
			                                                      : sfd_pkg::PH_HUNT;
		endcase
	end

	always_comb begin
		load_sync = 1'b0;
		load_type = 1'b0;
		load_data = 1'b0;
		push      = 1'b0;
		case (phase_q)
			sfd_pkg::PH_TYPE:  load_type = take & type_ok;
			sfd_pkg::PH_DATA:  load_data = take;
			sfd_pkg::PH_CHECK: ;
			sfd_pkg::PH_END:   push = take & (b == sfd_pkg::END_BYTE);
			default:           load_sync = take & (b == sfd_pkg::SYNC_BYTE);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HUNT;
			count_q <= 3'd0;
			check_q <= 8'd0;
			type_q  <= 3'd0;
		end else if (take) begin
			phase_q <= phase_d;
			if (load_sync) begin
				check_q <= sfd_pkg::SYNC_BYTE;
			end
			if (load_type) begin
				type_q  <= b[2:0];
				check_q <= check_q ^ b;
				count_q <= 3'd0;
			end
			if (load_data) begin
				check_q <= check_q ^ b;
				count_q <= count_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_data) begin
			store_q[count_q] <= b;
		end
	end

	assign frame.frame_type = type_q;
	assign frame.word_zero  = {store_q[0], store_q[1]};
	assign frame.word_one   = {store_q[2], store_q[3]};
	assign frame.word_two   = {store_q[4], store_q[5]};
	assign frame.word_three = {store_q[6], store_q[7]};

endmodule

### rtl/core/sfd_queue.sv
module sfd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfd_pkg::frame_t push_data,
	input  logic            pop,
	output sfd_pkg::frame_t pop_data,
	output logic            full,
	output logic            empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	sfd_pkg::frame_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/sfd_tracker.sv
module sfd_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfd_pkg::type_codes_t codes,
	input  logic                 q_empty,
	input  sfd_pkg::frame_t      q_data,
	output logic                 pop,
	sfd_result_if.source         frame_ch
);

	logic [2:0]      seen_q;
	logic [2:0]      hit;
	logic [2:0]      seen_n;
	logic            complete;
	logic            out_valid_q;
	logic            out_cmpl_q;
	sfd_pkg::frame_t out_q;

	assign pop = ~q_empty & (~out_valid_q | frame_ch.ready);

	always_comb begin
		hit = 3'b000;
		if (q_data.frame_type == codes.gyro) begin
			hit = 3'b001;
		end else if (q_data.frame_type == codes.accel) begin
			hit = 3'b010;
		end else if (q_data.frame_type == codes.orient) begin
			hit = 3'b100;
		end
	end

	assign seen_n   = seen_q | hit;
	assign complete = &seen_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 3'b000;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				seen_q      <= complete ? 3'b000 : seen_n;
				out_valid_q <= 1'b1;
			end else if (frame_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q      <= q_data;
			out_cmpl_q <= complete;
		end
	end

	assign frame_ch.valid            = out_valid_q;
	assign frame_ch.frame_type       = out_q.frame_type;
	assign frame_ch.word_zero        = out_q.word_zero;
	assign frame_ch.word_one         = out_q.word_one;
	assign frame_ch.word_two         = out_q.word_two;
	assign frame_ch.word_three       = out_q.word_three;
	assign frame_ch.imu_set_complete = out_cmpl_q;

endmodule

### rtl/core/serial_frame_deframer.sv
// Serial frame deframer. Takes one received byte per cycle on byte_ch and
// finds 12-byte frames (0xFC, type 1..5, eight payload bytes, XOR check over
// all earlier bytes, 0xDF); each good frame gives one request on frame_ch
// with its type, four big-endian payload words and the IMU set flag. Bytes
// are accepted back to back, one per cycle; byte_ch.ready drops only while the
// parser waits for an end byte and the frame queue (QUEUE_DEPTH entries) is
// full. An accepted end byte writes the frame into the queue, and from there
// it moves to the output register behind frame_ch.valid. The type codes of
// the three IMU kinds are set through the APB port at byte addresses 0x0, 0x4
// and 0x8 and are to be written only while no frame is in flight.
module serial_frame_deframer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sfd_byte_if.sink                   byte_ch,
	sfd_result_if.source               frame_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	sfd_pkg::type_codes_t  codes;
	sfd_pkg::frame_t       push_frame;
	sfd_pkg::frame_t       pop_frame;
	logic                  q_push;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;

	sfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.codes   (codes)
	);

	sfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.q_full  (q_full),
		.push    (q_push),
		.frame   (push_frame)
	);

	sfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_frame),
		.pop       (q_pop),
		.pop_data  (pop_frame),
		.full      (q_full),
		.empty     (q_empty)
	);

	sfd_tracker u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.codes    (codes),
		.q_empty  (q_empty),
		.q_data   (pop_frame),
		.pop      (q_pop),
		.frame_ch (frame_ch)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame queue overflow");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("pushed frame missing from queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty frame queue");
`endif

endmodule

### tb/sv/serial_frame_deframer_tb.sv
module serial_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW             = sfd_pkg::ADDR_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 12;
	localparam int PHASE_BYTES    = 260;
	localparam int N_PHASES       = 7;

	typedef enum logic [1:0] {
		FR_GOOD,
		FR_BAD_CHECK,
		FR_BAD_END,
		FR_TRUNC
	} fault_t;

	typedef struct packed {
		sfd_pkg::frame_t frame;
		logic            set_done;
	} frame_rec_t;

	typedef struct packed {
		logic [7:0]  kind;
		logic [63:0] payload;
		fault_t      fault;
		logic        typed;
		logic        rnd;
		logic        done;
	} frame_row_t;

	// typed rows: result type/words read straight from kind/payload
	localparam frame_row_t DIR_ROWS [13] = '{
		'{8'h03, 64'h0000_0000_0000_0000, FR_GOOD,      1'b1, 1'b0, 1'b0},
		'{8'h04, 64'hFFFF_FFFF_FFFF_FFFF, FR_GOOD,      1'b1, 1'b0, 1'b0},
		'{8'h00, 64'h0000_0000_0000_0000, FR_GOOD,      1'b0, 1'b0, 1'b0},
		'{8'h06, 64'h0000_0000_0000_0000, FR_GOOD,      1'b0, 1'b0, 1'b0},
		'{8'h05, 64'hFCFC_FCFC_FCFC_FCFC, FR_BAD_CHECK, 1'b0, 1'b0, 1'b0},
		'{8'h05, 64'hFCDF_FCDF_FCDF_FCDF, FR_BAD_END,   1'b0, 1'b0, 1'b0},
		'{8'h05, 64'hFCFC_FCFC_FCFC_FCFC, FR_GOOD,      1'b1, 1'b0, 1'b1},
		'{8'h01, 64'h0102_0304_0506_0708, FR_GOOD,      1'b1, 1'b0, 1'b0},
		'{8'h02, 64'h8040_2010_0804_0201, FR_GOOD,      1'b1, 1'b0, 1'b0},
		'{8'hFF, 64'h0000_0000_0000_0000, FR_GOOD,      1'b0, 1'b0, 1'b0},
		'{8'h03, 64'h0000_0000_0000_0000, FR_GOOD,      1'b0, 1'b1, 1'b0},
		'{8'h04, 64'h0000_0000_0000_0000, FR_TRUNC,     1'b0, 1'b1, 1'b0},
		'{8'h04, 64'h0000_0000_0000_0000, FR_GOOD,      1'b0, 1'b1, 1'b0}
	};

	localparam sfd_pkg::type_codes_t PHASE_CODES [N_PHASES] = '{
		'{3'd3, 3'd4, 3'd5},
		'{3'd1, 3'd2, 3'd3},
		'{3'd5, 3'd5, 3'd5},
		'{3'd1, 3'd1, 3'd5},
		'{3'd0, 3'd6, 3'd7},
		'{3'd7, 3'd0, 3'd1},
		'{3'd5, 3'd1, 3'd3}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [AW-1:0] paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	sfd_byte_if   byte_ch ();
	sfd_result_if frame_ch ();

	serial_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.frame_ch (frame_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser and tracker mirror
	sfd_pkg::phase_t      p_phase;
	logic [2:0]           p_count;
	logic [7:0]           p_check;
	logic [2:0]           p_type;
	logic [7:0]           p_store [8];
	logic [2:0]           p_seen;
	sfd_pkg::type_codes_t p_codes;

	frame_rec_t pending_frames [$];
	frame_rec_t last_rx;
	int         rx_count = 0;
	int         err_count = 0;
	int         idle_cycles = 0;
	int         src_idle_pct = 0;
	int         sink_idle_pct = 0;
	bit         hold_req = 1'b0;

	function automatic logic deframe_byte(input logic [7:0] b, output frame_rec_t rec);
		logic hit;
		hit = 1'b0;
		rec = '0;
		case (p_phase)
			sfd_pkg::PH_TYPE: begin
				if (b >= sfd_pkg::TYPE_MIN && b <= sfd_pkg::TYPE_MAX) begin
					p_type = b[2:0];
					p_check = p_check ^ b;
					p_count = 3'd0;
					p_phase = sfd_pkg::PH_DATA;
				end else
					p_phase = sfd_pkg::PH_HUNT;
			end
			sfd_pkg::PH_DATA: begin
				p_store[p_count] = b;
				p_check = p_check ^ b;
				if (p_count == 3'd7) begin
					p_count = 3'd0;
					p_phase = sfd_pkg::PH_CHECK;
				end else
					p_count = p_count + 3'd1;
			end
			sfd_pkg::PH_CHECK:
				p_phase = (b == p_check) ? sfd_pkg::PH_END : sfd_pkg::PH_HUNT;
			sfd_pkg::PH_END: begin
				p_phase = sfd_pkg::PH_HUNT;
				if (b == sfd_pkg::END_BYTE) begin
					// first matching code wins
					if (p_type == p_codes.gyro)
						p_seen[0] = 1'b1;
					else if (p_type == p_codes.accel)
						p_seen[1] = 1'b1;
					else if (p_type == p_codes.orient)
						p_seen[2] = 1'b1;
					if (p_seen == 3'b111) begin
						rec.set_done = 1'b1;
						p_seen = 3'b000;
					end
					rec.frame.frame_type = p_type;
					rec.frame.word_zero  = {p_store[0], p_store[1]};
					rec.frame.word_one   = {p_store[2], p_store[3]};
					rec.frame.word_two   = {p_store[4], p_store[5]};
					rec.frame.word_three = {p_store[6], p_store[7]};
					hit = 1'b1;
				end
			end
			default: begin
				p_phase = sfd_pkg::PH_HUNT;
				if (b == sfd_pkg::SYNC_BYTE) begin
					p_check = sfd_pkg::SYNC_BYTE;
					p_phase = sfd_pkg::PH_TYPE;
				end
			end
		endcase
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin : monitor
		frame_rec_t rec;
		frame_rec_t want;
		logic       progress;
		if (arst_n) begin
			progress = 1'b0;
			if (psel)
				progress = 1'b1;
			if (psel && penable && pwrite && pready) begin
				case (paddr[AW-1:2])
					sfd_pkg::REG_GYRO:   p_codes.gyro = pwdata[2:0];
					sfd_pkg::REG_ACCEL:  p_codes.accel = pwdata[2:0];
					sfd_pkg::REG_ORIENT: p_codes.orient = pwdata[2:0];
					default: ;
				endcase
			end
			if (byte_ch.valid && byte_ch.ready) begin
				progress = 1'b1;
				if (deframe_byte(byte_ch.rx_byte, rec))
					pending_frames = {pending_frames, rec};
			end
			if (frame_ch.valid && frame_ch.ready) begin
				progress = 1'b1;
				rec.frame.frame_type = frame_ch.frame_type;
				rec.frame.word_zero  = frame_ch.word_zero;
				rec.frame.word_one   = frame_ch.word_one;
				rec.frame.word_two   = frame_ch.word_two;
				rec.frame.word_three = frame_ch.word_three;
				rec.set_done         = frame_ch.imu_set_complete;
				if (pending_frames.size() == 0)
					report_mismatch("unexpected frame", 64'(rec.frame), 64'h0);
				else begin
					want = pending_frames.pop_front();
					if (rec.frame.frame_type !== want.frame.frame_type)
						report_mismatch("frame_type", 64'(rec.frame.frame_type),
							64'(want.frame.frame_type));
					if (rec.frame.word_zero !== want.frame.word_zero)
						report_mismatch("word_zero", 64'(rec.frame.word_zero),
							64'(want.frame.word_zero));
					if (rec.frame.word_one !== want.frame.word_one)
						report_mismatch("word_one", 64'(rec.frame.word_one),
							64'(want.frame.word_one));
					if (rec.frame.word_two !== want.frame.word_two)
						report_mismatch("word_two", 64'(rec.frame.word_two),
							64'(want.frame.word_two));
					if (rec.frame.word_three !== want.frame.word_three)
						report_mismatch("word_three", 64'(rec.frame.word_three),
							64'(want.frame.word_three));
					if (rec.set_done !== want.set_done)
						report_mismatch("imu_set_complete", 64'(rec.set_done),
							64'(want.set_done));
				end
				last_rx = rec;
				rx_count++;
			end
			if (progress)
				idle_cycles = 0;
			else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	// result side: random short stalls, one long hold-off on request
	initial begin : frame_sink
		int gap;
		frame_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				frame_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
				gap = $urandom_range(1, 3);
				frame_ch.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else
				frame_ch.ready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		byte_ch.valid <= 1'b1;
		byte_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!byte_ch.ready);
	endtask

	task automatic feed_byte(input logic [7:0] b);
		if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] kind, input logic [63:0] payload,
			input fault_t fault, output int n);
		logic [7:0] fr [12];
		logic [7:0] sum;
		fr[0] = sfd_pkg::SYNC_BYTE;
		fr[1] = kind;
		for (int i = 0; i < 8; i++)
			fr[2 + i] = payload[63 - 8 * i -: 8];
		sum = 8'h00;
		for (int i = 0; i < 10; i++)
			sum = sum ^ fr[i];
		fr[10] = sum;
		fr[11] = sfd_pkg::END_BYTE;
		n = 12;
		// single bit flips keep a bad end byte off the sync value
		case (fault)
			FR_BAD_CHECK: fr[10] = sum ^ (8'd1 << $urandom_range(0, 7));
			FR_BAD_END:   fr[11] = sfd_pkg::END_BYTE ^ (8'd1 << $urandom_range(0, 7));
			FR_TRUNC:     n = $urandom_range(2, 11);
			default: ;
		endcase
		for (int i = 0; i < n; i++)
			feed_byte(fr[i]);
	endtask

	task automatic drain_frames(input int extra);
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [2:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'({idx, 2'b00});
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(input logic [1:0] idx, input logic [2:0] want);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= AW'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== 32'(want))
			report_mismatch("register read", 64'(got), 64'(want));
	endtask

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 30;
		endcase
	endfunction

	task automatic random_traffic(input int n_bytes);
		int         sent;
		int         pick;
		int         n;
		logic [7:0] kind;
		fault_t     fault;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// line noise between frames
				repeat ($urandom_range(1, 6))
					feed_byte(($urandom_range(0, 3) == 0) ? sfd_pkg::SYNC_BYTE
						: 8'($urandom));
			end else begin
				kind = 8'($urandom_range(1, 5));
				fault = FR_GOOD;
				if (pick < 10)
					kind = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(6, 255));
				else if (pick < 20)
					fault = FR_BAD_CHECK;
				else if (pick < 27)
					fault = FR_BAD_END;
				else if (pick < 32)
					fault = FR_TRUNC;
				send_frame(kind, {$urandom, $urandom}, fault, n);
				sent += n;
			end
		end
	endtask

	initial begin : stimulus
		frame_row_t  row;
		logic [63:0] payload;
		int          base;
		int          n;
		byte_ch.valid <= 1'b0;
		byte_ch.rx_byte <= 8'h00;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'h0;
		p_phase = sfd_pkg::PH_HUNT;
		p_count = 3'd0;
		p_check = 8'h00;
		p_type = 3'd0;
		p_seen = 3'b000;
		p_codes = {sfd_pkg::GYRO_RST, sfd_pkg::ACCEL_RST, sfd_pkg::ORIENT_RST};
		for (int i = 0; i < 8; i++)
			p_store[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_read_check(sfd_pkg::REG_GYRO, sfd_pkg::GYRO_RST);
		reg_read_check(sfd_pkg::REG_ACCEL, sfd_pkg::ACCEL_RST);
		reg_read_check(sfd_pkg::REG_ORIENT, sfd_pkg::ORIENT_RST);

		src_idle_pct = 15;
		sink_idle_pct = 15;
		for (int r = 0; r < 13; r++) begin
			row = DIR_ROWS[r];
			payload = row.rnd ? {$urandom, $urandom} : row.payload;
			base = rx_count;
			send_frame(row.kind, payload, row.fault, n);
			if (row.typed) begin
				drain_frames(0);
				if (rx_count != base + 1)
					report_mismatch("frame count", 64'(rx_count), 64'(base + 1));
				else begin
					if (last_rx.frame.frame_type !== row.kind[2:0])
						report_mismatch("typed frame_type", 64'(last_rx.frame.frame_type),
							64'(row.kind[2:0]));
					if ({last_rx.frame.word_zero, last_rx.frame.word_one,
							last_rx.frame.word_two, last_rx.frame.word_three} !== payload)
						report_mismatch("typed words", {last_rx.frame.word_zero,
							last_rx.frame.word_one, last_rx.frame.word_two,
							last_rx.frame.word_three}, payload);
					if (last_rx.set_done !== row.done)
						report_mismatch("typed imu_set_complete", 64'(last_rx.set_done),
							64'(row.done));
				end
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_frames(SETTLE_CYCLES);
			reg_write(sfd_pkg::REG_GYRO, PHASE_CODES[ph].gyro);
			reg_write(sfd_pkg::REG_ACCEL, PHASE_CODES[ph].accel);
			reg_write(sfd_pkg::REG_ORIENT, PHASE_CODES[ph].orient);
			reg_read_check(sfd_pkg::REG_GYRO, PHASE_CODES[ph].gyro);
			reg_read_check(sfd_pkg::REG_ACCEL, PHASE_CODES[ph].accel);
			reg_read_check(sfd_pkg::REG_ORIENT, PHASE_CODES[ph].orient);
			if (ph == N_PHASES - 1) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct = pick_idle_pct();
				sink_idle_pct = pick_idle_pct();
			end
			// back up the frame queue so byte input stalls on an end byte
			if (ph == 1)
				hold_req = 1'b1;
			random_traffic(PHASE_BYTES);
		end

		drain_frames(SETTLE_CYCLES);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
